FILE: rtl/s1bsh_pkg.sv
// Shared types, constants and round helpers for the SHA-1 byte stream hasher.
// No dependencies; used by s1bsh_round and sha1_byte_stream_hasher_top.
`timescale 1ns / 1ps

package s1bsh_pkg;

  localparam int WordW  = 32;
  localparam int RoundW = 7;
  localparam int CntW   = 6;
  localparam int LenW   = 64;

  localparam logic [RoundW-1:0] LastRound = 7'd79;

  localparam logic [WordW-1:0] Iv0 = 32'h67452301;
  localparam logic [WordW-1:0] Iv1 = 32'hefcdab89;
  localparam logic [WordW-1:0] Iv2 = 32'h98badcfe;
  localparam logic [WordW-1:0] Iv3 = 32'h10325476;
  localparam logic [WordW-1:0] Iv4 = 32'hc3d2e1f0;

  localparam logic [7:0] PadByte = 8'h80;

  // a..e working variables of one compression
  typedef struct packed {
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] c;
    logic [WordW-1:0] d;
    logic [WordW-1:0] e;
  } work_t;

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] r);
    logic [WordW-1:0] k;
    if (r < 7'd20)      k = 32'h5a827999;
    else if (r < 7'd40) k = 32'h6ed9eba1;
    else if (r < 7'd60) k = 32'h8f1bbcdc;
    else                k = 32'hca62c1d6;
    return k;
  endfunction

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input int unsigned n);
    return (x << n) | (x >> (WordW - n));
  endfunction

endpackage

FILE: rtl/sha1_byte_stream_hasher_top.sv
// SHA-1 hasher top level: byte packing, block window, sequencer, padding and digest out.
// Depends on s1bsh_pkg and s1bsh_round.
`timescale 1ns / 1ps

// Message bytes enter one beat at a time on the in_ stream (in_tuser high when the
// beat carries a byte, in_tlast high to end the message; an end beat with no byte is
// allowed, so the empty message works). Every 64th byte starts a compression on a
// single shared round unit, one round per cycle: 80 rounds, then the chaining add,
// with in_tready low throughout. After the end beat the block feeds its own padding
// and length bytes (9 to 72 of them), one per cycle except while a compression runs,
// with one or two more compressions, then presents the five digest words on the
// out_ stream, word 0 first, out_tlast on word 4, and returns to idle with its state cleared.
module sha1_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] msg_byte
  input  logic        in_tuser,   // has_byte
  input  logic        in_tlast,   // is_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COMP = 3'd1;
  localparam logic [2:0] ST_FIN  = 3'd2;
  localparam logic [2:0] ST_PAD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [2:0] LastIdx = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [s1bsh_pkg::CntW-1:0]        cnt_r, cnt_nxt;
  logic [s1bsh_pkg::LenW-1:0]        bits_r, bits_nxt;
  logic [s1bsh_pkg::RoundW-1:0]      rnd_r, rnd_nxt;
  logic [2:0]                        idx_r, idx_nxt;
  logic                              last_r, last_nxt;
  logic                              sent80_r, sent80_nxt;
  logic                              lenph_r, lenph_nxt;
  logic [23:0]                       acc_r, acc_nxt;
  logic [s1bsh_pkg::WordW-1:0]       chain_r [5];
  logic [s1bsh_pkg::WordW-1:0]       win_r [16];
  s1bsh_pkg::work_t                  ws_r, ws_nxt, ws_rnd, chain_w;

  logic                              absorb;
  logic [7:0]                        abs_byte;
  logic [s1bsh_pkg::WordW-1:0]       full_word;
  logic                              push_byte;
  logic                              push_rnd;
  logic [s1bsh_pkg::WordW-1:0]       wr;
  logic                              block_done;
  logic                              chain_add;
  logic                              chain_clr;
  logic                              in_acc;
  logic                              out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  assign chain_w = '{a: chain_r[0], b: chain_r[1], c: chain_r[2],
                     d: chain_r[3], e: chain_r[4]};

  // schedule word: first 16 rounds recycle the block, then expand in place
  assign wr = (rnd_r < 7'd16) ? win_r[0]
            : s1bsh_pkg::rotl(win_r[13] ^ win_r[8] ^ win_r[2] ^ win_r[0], 1);

  s1bsh_round u_round (
    .cur (ws_r),
    .wr  (wr),
    .rnd (rnd_r),
    .nxt (ws_rnd)
  );

  assign full_word  = {acc_r, abs_byte};
  assign push_byte  = absorb && (cnt_r[1:0] == 2'd3);
  assign push_rnd   = (state_r == ST_COMP);
  assign block_done = absorb && (cnt_r == 6'd63);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == LastIdx);

  always_comb begin
    case (idx_r)
      3'd0:    out_tdata = chain_r[0];
      3'd1:    out_tdata = chain_r[1];
      3'd2:    out_tdata = chain_r[2];
      3'd3:    out_tdata = chain_r[3];
      default: out_tdata = chain_r[4];
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    bits_nxt   = bits_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    sent80_nxt = sent80_r;
    lenph_nxt  = lenph_r;
    ws_nxt     = ws_r;
    absorb     = 1'b0;
    abs_byte   = in_tdata;
    chain_add  = 1'b0;
    chain_clr  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          last_nxt = in_tlast;
          if (in_tuser) begin
            absorb   = 1'b1;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_tuser && cnt_r == 6'd63) begin
            state_nxt = ST_COMP;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        absorb = 1'b1;
        if (!sent80_r) begin
          abs_byte   = s1bsh_pkg::PadByte;
          sent80_nxt = 1'b1;
        end else if (lenph_r || cnt_r == 6'd56) begin
          // length goes out most significant byte first
          abs_byte  = bits_r[63:56];
          bits_nxt  = bits_r << 8;
          lenph_nxt = 1'b1;
        end else begin
          abs_byte = 8'h00;
        end
        if (cnt_r == 6'd63) state_nxt = ST_COMP;
      end
      ST_COMP: begin
        ws_nxt  = ws_rnd;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == s1bsh_pkg::LastRound) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        chain_add = 1'b1;
        if (lenph_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = 3'd0;
        end else if (last_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LastIdx) begin
            chain_clr  = 1'b1;
            state_nxt  = ST_IDLE;
            cnt_nxt    = '0;
            bits_nxt   = '0;
            last_nxt   = 1'b0;
            sent80_nxt = 1'b0;
            lenph_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (absorb) cnt_nxt = cnt_r + 6'd1;
    if (block_done) begin
      ws_nxt  = chain_w;
      rnd_nxt = '0;
    end
    acc_nxt = absorb ? full_word[23:0] : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      bits_r   <= '0;
      rnd_r    <= '0;
      idx_r    <= '0;
      last_r   <= 1'b0;
      sent80_r <= 1'b0;
      lenph_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      bits_r   <= bits_nxt;
      rnd_r    <= rnd_nxt;
      idx_r    <= idx_nxt;
      last_r   <= last_nxt;
      sent80_r <= sent80_nxt;
      lenph_r  <= lenph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || chain_clr) begin
      chain_r[0] <= s1bsh_pkg::Iv0;
      chain_r[1] <= s1bsh_pkg::Iv1;
      chain_r[2] <= s1bsh_pkg::Iv2;
      chain_r[3] <= s1bsh_pkg::Iv3;
      chain_r[4] <= s1bsh_pkg::Iv4;
    end else if (chain_add) begin
      chain_r[0] <= chain_r[0] + ws_r.a;
      chain_r[1] <= chain_r[1] + ws_r.b;
      chain_r[2] <= chain_r[2] + ws_r.c;
      chain_r[3] <= chain_r[3] + ws_r.d;
      chain_r[4] <= chain_r[4] + ws_r.e;
    end
  end

  // block window: bytes fill it a word at a time, rounds rotate and expand it
  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    ws_r  <= ws_nxt;
    if (push_byte || push_rnd) begin
      for (int i = 0; i < 15; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[15] <= push_rnd ? wr : full_word;
    end
  end

endmodule

FILE: rtl/s1bsh_round.sv
// One SHA-1 round: boolean function, constant and the five-operand add.
// Depends on s1bsh_pkg.
`timescale 1ns / 1ps

module s1bsh_round (
  input  s1bsh_pkg::work_t                     cur,
  input  logic [s1bsh_pkg::WordW-1:0]          wr,
  input  logic [s1bsh_pkg::RoundW-1:0]         rnd,
  output s1bsh_pkg::work_t                     nxt
);

  logic [s1bsh_pkg::WordW-1:0] f;
  logic [s1bsh_pkg::WordW-1:0] t;

  always_comb begin
    if (rnd < 7'd20) begin
      f = ((cur.c ^ cur.d) & cur.b) ^ cur.d;
    end else if (rnd < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
    end else if (rnd < 7'd60) begin
      f = (cur.b & cur.c) | (cur.d & (cur.b | cur.c));
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
    end
    t = s1bsh_pkg::rotl(cur.a, 5) + f + cur.e + wr + s1bsh_pkg::round_k(rnd);
    nxt.a = t;
    nxt.b = cur.a;
    nxt.c = s1bsh_pkg::rotl(cur.b, 30);
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule
